// File: rtl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [7:0] RESET_COLOR  = 8'h07;
    localparam logic [7:0] NEWLINE_CODE = 8'h0a;
    localparam logic [7:0] SPACE_CODE   = 8'h20;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_READ,
        OP_CLEAR
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_column;
    } t_op;

    typedef struct packed {
        logic init_busy;
        logic op_pop;
    } t_back_status;

endpackage
`default_nettype wire

// File: rtl/tcw_front.sv
`default_nettype none
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire                             i_tvalid,
    output logic                            o_tready,
    input  wire  [tcw_pkg::IN_TDATA_W-1:0]  i_tdata,
    input  wire                             i_init_busy,
    input  wire                             i_q_full,
    output logic                            o_push,
    output tcw_pkg::t_op                    o_op
);

    logic [1:0] cmd;
    logic       in_range;

    assign cmd      = i_tdata[1:0];
    assign in_range = (32'(i_tdata[14:10]) < 32'(ROWS)) && (32'(i_tdata[21:15]) < 32'(COLUMNS));

    always_comb begin
        o_op.char_code   = i_tdata[9:2];
        o_op.read_row    = i_tdata[14:10];
        o_op.read_column = i_tdata[21:15];
        unique case (cmd)
            tcw_pkg::CMD_PUT: begin
                o_op.kind = (i_tdata[9:2] == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE
                                                                   : tcw_pkg::OP_PUT;
            end
            tcw_pkg::CMD_READ: begin
                // reads off the screen give an empty cell
                o_op.kind = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
            end
            tcw_pkg::CMD_CLEAR: begin
                o_op.kind = tcw_pkg::OP_CLEAR;
            end
            default: begin
                o_op.kind = tcw_pkg::OP_NOP;
            end
        endcase
    end

    assign o_tready = !i_q_full && !i_init_busy;
    assign o_push   = i_tvalid && o_tready;

endmodule
`default_nettype wire

// File: rtl/tcw_queue.sv
`default_nettype none
module tcw_queue (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  tcw_pkg::t_op i_op,
    output logic         o_full,
    input  wire          i_pop,
    output logic         o_valid,
    output tcw_pkg::t_op o_op
);

    localparam int PTR_W = $clog2(tcw_pkg::QUEUE_DEPTH);

    tcw_pkg::t_op   r_slot [tcw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    assign o_full  = (r_count == (PTR_W+1)'(tcw_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

endmodule
`default_nettype wire

// File: rtl/tcw_back.sv
`default_nettype none
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_op_valid,
    input  tcw_pkg::t_op         i_op,
    output tcw_pkg::t_back_status o_status,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [7:0]           i_cfg_data,
    output logic                 o_res_valid,
    input  wire                  i_res_ready,
    output logic [7:0]           o_cell_char,
    output logic [7:0]           o_cell_color,
    output logic [6:0]           o_cursor_column,
    output logic [4:0]           o_cursor_row
);

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = ROWS * (2 ** COL_W);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_FILL   = 4'b0100,
        S_SCROLL = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [ROW_W-1:0] r_top, n_top;
    logic [7:0]       r_color, n_color;
    logic [ROW_W-1:0] r_fill_row, n_fill_row;
    logic [COL_W-1:0] r_fill_col, n_fill_col;
    logic             r_fill_init, n_fill_init;
    logic [7:0]       r_fill_color, n_fill_color;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_char, n_out_char;
    logic [7:0]       r_out_color, n_out_color;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic [15:0]      r_rd_data;
    logic [15:0]      r_mem [DEPTH];

    logic [ROW_W:0]   cur_sum;
    logic [ROW_W:0]   rd_sum;
    logic [ROW_W-1:0] cur_phys;
    logic [ROW_W-1:0] rd_phys;
    logic [COL_W:0]   col_inc;
    logic             last_row;
    logic             pop;
    logic             newline;
    logic             emit;
    logic [15:0]      emit_cell;
    logic             we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]      wdata;
    logic             rd_en;
    logic [ADDR_W-1:0] raddr;

    // logical row to physical row through the scroll offset
    assign cur_sum  = {1'b0, r_row} + {1'b0, r_top};
    assign cur_phys = (cur_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(cur_sum - (ROW_W+1)'(ROWS))
                                                    : ROW_W'(cur_sum);
    assign rd_sum   = (ROW_W+1)'(i_op.read_row) + {1'b0, r_top};
    assign rd_phys  = (rd_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(rd_sum - (ROW_W+1)'(ROWS))
                                                   : ROW_W'(rd_sum);
    assign raddr    = {rd_phys, COL_W'(i_op.read_column)};

    assign col_inc  = {1'b0, r_col} + (COL_W+1)'(1);
    assign last_row = (r_row == ROW_W'(ROWS - 1));
    assign pop      = (r_state == S_IDLE) && i_op_valid && !r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_top        = r_top;
        n_color      = r_color;
        n_fill_row   = r_fill_row;
        n_fill_col   = r_fill_col;
        n_fill_init  = r_fill_init;
        n_fill_color = r_fill_color;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out_char   = r_out_char;
        n_out_color  = r_out_color;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        newline      = 1'b0;
        emit         = 1'b0;
        emit_cell    = '0;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        rd_en        = 1'b0;

        if (i_cfg_valid) begin
            n_color = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    unique case (i_op.kind)
                        tcw_pkg::OP_PUT: begin
                            we    = 1'b1;
                            waddr = {cur_phys, r_col};
                            wdata = {r_color, i_op.char_code};
                            if (col_inc < (COL_W+1)'(COLUMNS)) begin
                                n_col = COL_W'(col_inc);
                                emit  = 1'b1;
                            end else begin
                                newline = 1'b1;
                            end
                        end
                        tcw_pkg::OP_NEWLINE: begin
                            newline = 1'b1;
                        end
                        tcw_pkg::OP_READ: begin
                            rd_en   = 1'b1;
                            n_state = S_READ;
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_state      = S_FILL;
                            n_fill_row   = '0;
                            n_fill_col   = '0;
                            n_fill_init  = 1'b0;
                            n_fill_color = r_color;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                    if (newline) begin
                        n_col = '0;
                        if (!last_row) begin
                            n_row = r_row + ROW_W'(1);
                            emit  = 1'b1;
                        end else begin
                            // old top row becomes the new bottom row
                            n_state    = S_SCROLL;
                            n_fill_col = '0;
                        end
                    end
                end
            end
            S_READ: begin
                emit      = 1'b1;
                emit_cell = r_rd_data;
                n_state   = S_IDLE;
            end
            S_FILL: begin
                we    = 1'b1;
                waddr = {r_fill_row, r_fill_col};
                wdata = {r_fill_color, tcw_pkg::SPACE_CODE};
                if (r_fill_col == COL_W'(COLUMNS - 1)) begin
                    n_fill_col = '0;
                    if (r_fill_row == ROW_W'(ROWS - 1)) begin
                        n_state     = S_IDLE;
                        n_fill_init = 1'b0;
                        emit        = !r_fill_init;
                    end else begin
                        n_fill_row = r_fill_row + ROW_W'(1);
                    end
                end else begin
                    n_fill_col = r_fill_col + COL_W'(1);
                end
            end
            S_SCROLL: begin
                we    = 1'b1;
                waddr = {r_top, r_fill_col};
                wdata = {r_color, tcw_pkg::SPACE_CODE};
                if (r_fill_col == COL_W'(COLUMNS - 1)) begin
                    n_top   = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + ROW_W'(1);
                    n_state = S_IDLE;
                    emit    = 1'b1;
                end else begin
                    n_fill_col = r_fill_col + COL_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_char  = emit_cell[7:0];
            n_out_color = emit_cell[15:8];
            n_out_col   = n_col;
            n_out_row   = n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_FILL;
            r_col        <= '0;
            r_row        <= '0;
            r_top        <= '0;
            r_color      <= tcw_pkg::RESET_COLOR;
            r_fill_row   <= '0;
            r_fill_col   <= '0;
            r_fill_init  <= 1'b1;
            r_fill_color <= tcw_pkg::RESET_COLOR;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_top        <= n_top;
            r_color      <= n_color;
            r_fill_row   <= n_fill_row;
            r_fill_col   <= n_fill_col;
            r_fill_init  <= n_fill_init;
            r_fill_color <= n_fill_color;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char  <= n_out_char;
        r_out_color <= n_out_color;
        r_out_col   <= n_out_col;
        r_out_row   <= n_out_row;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    assign o_status.init_busy = r_fill_init;
    assign o_status.op_pop    = pop;
    assign o_cfg_ready        = 1'b1;
    assign o_res_valid        = r_out_valid;
    assign o_cell_char        = r_out_char;
    assign o_cell_color       = r_out_color;
    assign o_cursor_column    = 7'(r_out_col);
    assign o_cursor_row       = 5'(r_out_row);

`ifndef SYNTHESIS
    a_read_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> $past(pop && i_op.kind == tcw_pkg::OP_READ))
        else $error("read state entered without a read request");

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= ROW_W'(ROWS - 1)) && (r_col <= COL_W'(COLUMNS - 1)))
        else $error("cursor left the screen");

    a_scroll_from_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCROLL |-> (r_row == ROW_W'(ROWS - 1)) && (r_col == '0))
        else $error("scroll pass with cursor off the last row start");

    a_no_pop_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_init |-> !pop && !r_out_valid)
        else $error("request taken during the reset clearing pass");
`endif

endmodule
`default_nettype wire

// File: rtl/text_console_writer_top.sv
`default_nettype none
// text-mode console engine with a COLUMNS x ROWS screen of char/color cells and a cursor
// s_axis: one request per beat (put character, read cell, clear screen)
// m_axis: exactly one result per request, in request order, carrying the read cell
//   (zero for other requests) and the cursor position after the request
// cfg: i_cfg_valid/o_cfg_ready/i_cfg_data write the color byte; o_cfg_ready is always high
// a two-entry request queue sits between the classifier and the screen engine, so
//   requests keep being taken while a result waits for m_axis_tready
// from the queue, a put, newline or empty read goes straight to the result register;
//   an on-screen read passes through the read state first, and a clear first sweeps
//   every cell; a newline or wrap that scrolls the screen first blanks one row
// the engine takes the next request only once its single result register is empty,
//   so it does not take a new request while a result is still waiting
// scrolling moves a row offset and blanks one row, so no screen copy is needed
// after reset the screen memory is swept to spaces in color 0x07, one cell a
//   cycle over all ROWS*COLUMNS cells (2000); s_axis_tready stays low meanwhile
// a stalled m_axis holds the result; the queue then fills and s_axis_tready drops
module text_console_writer_top #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    // command[1:0], char_code[9:2], read_row[14:10], read_column[21:15], zero above
    input  wire  [tcw_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    // cell_char[7:0], cell_color[15:8], cursor_column[22:16], cursor_row[27:23], zero above
    output logic [tcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [7:0]                      i_cfg_data
);

    tcw_pkg::t_op          front_op;
    tcw_pkg::t_op          queue_op;
    tcw_pkg::t_back_status back_status;
    logic                  push;
    logic                  q_full;
    logic                  q_valid;
    logic [7:0]            cell_char;
    logic [7:0]            cell_color;
    logic [6:0]            cursor_column;
    logic [4:0]            cursor_row;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_init_busy (back_status.init_busy),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_op        (front_op)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (back_status.op_pop),
        .o_valid (q_valid),
        .o_op    (queue_op)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (q_valid),
        .i_op            (queue_op),
        .o_status        (back_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .o_cell_char     (cell_char),
        .o_cell_color    (cell_color),
        .o_cursor_column (cursor_column),
        .o_cursor_row    (cursor_row)
    );

    assign m_axis_tdata = {4'b0000, cursor_row, cursor_column, cell_color, cell_char};

endmodule
`default_nettype wire
